// ===== hdl/swpp_pkg.sv =====
// Shared types, constants and state encoding for the spectrum window peak/power block.
package swpp_pkg;

    // Field and register widths
    localparam int PWR_W   = 16;
    localparam int CNT_W   = 13;
    localparam int FREQ_W  = 56;
    localparam int STEP_W  = 48;
    localparam int WIDTH_W = 55;
    localparam int CFG_W   = 56;
    localparam int IDX_W   = 3;
    localparam int BINF_W  = 57;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 38;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DEF_MAX_BINS = 4096;
    localparam int CNT_LIMIT    = 8191;

    // Fixed-point constants
    localparam logic [24:0] K_LOG2_10_Q32 = 25'd22293081;
    localparam logic [29:0] K_LN2_Q30     = 30'd744261118;
    localparam logic [23:0] K_DB64_Q16    = 24'd12626113;
    localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
    localparam logic signed [PWR_W-1:0] PWR_MINUS_300 = -16'sd19200;
    localparam logic signed [PWR_W-1:0] PWR_MAX       = 16'sh7FFF;
    localparam logic signed [PWR_W-1:0] PWR_MIN       = -16'sh8000;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_START = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP  = 3'd2;
    localparam logic [IDX_W-1:0] REG_LOW   = 3'd3;
    localparam logic [IDX_W-1:0] REG_HIGH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_WIDTH = 3'd5;

    // Search modes
    localparam logic [1:0] MODE_PEAK  = 2'd0;
    localparam logic [1:0] MODE_POWER = 2'd1;

    typedef logic signed [PWR_W-1:0]   t_pwr;
    typedef logic [CNT_W-1:0]          t_cnt;
    typedef logic signed [MUL_A_W-1:0] t_mul_a;
    typedef logic signed [MUL_B_W-1:0] t_mul_b;
    typedef logic signed [MUL_P_W-1:0] t_mul_p;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WIN,
        S_EXP,
        S_XLD,
        S_TMUL,
        S_TPROD,
        S_TDIV,
        S_TADD,
        S_ACC,
        S_BINEND,
        S_LNORM,
        S_LSQ,
        S_LSQ2,
        S_LDONE,
        S_SCALE,
        S_ROUND
    } t_state;

endpackage

// ===== hdl/swpp_mul.sv =====
// Shared signed multiplier with a registered product.
module swpp_mul (
    input  logic            i_clk,
    input  swpp_pkg::t_mul_a i_a,
    input  swpp_pkg::t_mul_b i_b,
    output swpp_pkg::t_mul_p o_p
);
    import swpp_pkg::*;

    // Product register
    always_ff @(posedge i_clk) begin
        o_p <= t_mul_p'(i_a) * t_mul_p'(i_b);
    end

endmodule

// ===== hdl/spectrum_window_peak_power_top.sv =====
// Top level: spectrum window peak search and integrated channel power.
// Bins enter one at a time while o_stall is low; the block then works on that bin alone.
// A bin outside the window skips the series. A bin inside the window runs the linear
// power conversion through one shared multiplier: 12 series terms, each a multiply, a
// divide by the term index done as a reciprocal multiply, and an add. On the last bin in
// power mode, unless the window is empty or the width is zero, two log2 evaluations follow,
// each a normalizing shift of one bit per step and 24 squaring steps, one for the sum and
// one for the window width, then scaling and rounding. Results sit in an output register,
// so the next bin is taken while a result waits.
module spectrum_window_peak_power_top #(
    parameter int MAX_BINS = swpp_pkg::DEF_MAX_BINS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [swpp_pkg::PWR_W-1:0] i_bin_power_dbm,
    input  logic                          i_last_bin,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [swpp_pkg::PWR_W-1:0] o_pick_dbm,
    output logic [swpp_pkg::CNT_W-1:0]    o_bins_in_window,
    input  logic                          i_cfg_we,
    input  logic [swpp_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [swpp_pkg::CFG_W-1:0]    i_cfg_data
);
    import swpp_pkg::*;

    localparam int COUNT_CAP = (MAX_BINS < CNT_LIMIT) ? MAX_BINS : CNT_LIMIT;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(COUNT_CAP);
    localparam logic signed [BINF_W:0] FREQ_SAT = {2'b00, {(BINF_W-1){1'b1}}};

    t_state r_state, n_state;

    // Configuration
    logic [1:0]               r_cfg_mode;
    logic signed [FREQ_W-1:0] r_cfg_start, r_cfg_lo, r_cfg_hi;
    logic [STEP_W-1:0]        r_cfg_step;
    logic [WIDTH_W-1:0]       r_cfg_width;

    // Per-bin and per-trace state
    t_pwr                     r_p, r_max, r_first;
    logic                     r_last, r_in_frame;
    logic signed [BINF_W-1:0] r_bin_freq;
    logic [31:0]              r_sum;
    logic signed [11:0]       r_exp;
    t_cnt                     r_cnt;
    logic                     r_inwin;

    // Exponential series
    logic signed [8:0]        r_n;
    logic [29:0]              r_x;
    logic [30:0]              r_term;
    logic [31:0]              r_m;
    logic [3:0]               r_k;
    logic [29:0]              r_dq;

    // Logarithm
    logic [WIDTH_W-1:0]       r_v;
    logic [5:0]               r_b;
    logic [30:0]              r_lm;
    logic [23:0]              r_frac;
    logic [4:0]               r_li;
    logic                     r_lsel;
    logic signed [MUL_A_W-1:0] r_total;

    t_mul_a mul_a;
    t_mul_b mul_b;
    t_mul_p r_prod;

    // Frame and window evaluation
    logic signed [BINF_W-1:0] cur_f;
    logic signed [BINF_W:0]   f_sum;
    logic                     in_win;
    assign cur_f  = r_in_frame ? r_bin_freq : BINF_W'(r_cfg_start);
    assign in_win = (cur_f >= BINF_W'(r_cfg_lo)) && (cur_f <= BINF_W'(r_cfg_hi));
    assign f_sum  = (BINF_W+1)'(cur_f) + $signed({10'b0, r_cfg_step});

    // Reciprocal of the series index, ceil(2^34 / k); exact floor for terms below 2^30
    function automatic logic [34:0] recip_k(input logic [3:0] k);
        logic [34:0] rcp;
        case (k)
            4'd1:    rcp = 35'd17179869184;
            4'd2:    rcp = 35'd8589934592;
            4'd3:    rcp = 35'd5726623062;
            4'd4:    rcp = 35'd4294967296;
            4'd5:    rcp = 35'd3435973837;
            4'd6:    rcp = 35'd2863311531;
            4'd7:    rcp = 35'd2454267027;
            4'd8:    rcp = 35'd2147483648;
            4'd9:    rcp = 35'd1908874354;
            4'd10:   rcp = 35'd1717986919;
            4'd11:   rcp = 35'd1561806290;
            default: rcp = 35'd1431655766; // index 12
        endcase
        return rcp;
    endfunction

    // Quotient of the reciprocal multiply
    logic [29:0] div_q;
    assign div_q = r_prod[63:34];

    // Accumulate aligned term
    logic [31:0]        acc_mm, acc_sum, acc_sh;
    logic signed [11:0] acc_nn, acc_exp;
    logic signed [12:0] acc_d;
    always_comb begin
        acc_mm  = r_m;
        acc_nn  = 12'(r_n);
        if (r_m[31]) begin
            acc_mm = r_m >> 1;
            acc_nn = 12'(r_n) + 12'sd1;
        end
        acc_d   = '0;
        acc_sh  = '0;
        acc_sum = acc_mm;
        acc_exp = acc_nn;
        if (r_sum != '0) begin
            if (acc_nn > r_exp) begin
                acc_d   = 13'(acc_nn) - 13'(r_exp);
                acc_sh  = (acc_d >= 13'sd32) ? '0 : (r_sum >> acc_d[4:0]);
                acc_sum = acc_sh + acc_mm;
            end else begin
                acc_d   = 13'(r_exp) - 13'(acc_nn);
                acc_sh  = (acc_d >= 13'sd32) ? '0 : (acc_mm >> acc_d[4:0]);
                acc_sum = r_sum + acc_sh;
                acc_exp = r_exp;
            end
        end
        if (acc_sum[31]) begin
            acc_sum = acc_sum >> 1;
            acc_exp = acc_exp + 12'sd1;
        end
    end

    // Squaring step result
    logic [31:0] sq;
    assign sq = r_prod[61:30];

    // Rounding of the scaled log
    logic signed [63:0] rnd_t;
    logic signed [23:0] rnd_q;
    t_pwr               rnd_sat;
    assign rnd_t = 64'(r_prod) + 64'sh80_0000_0000;
    assign rnd_q = 24'(rnd_t >>> 40);
    always_comb begin
        if (rnd_q > 24'(PWR_MAX))      rnd_sat = PWR_MAX;
        else if (rnd_q < 24'(PWR_MIN)) rnd_sat = PWR_MIN;
        else                           rnd_sat = rnd_q[PWR_W-1:0];
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_WIN:   begin mul_a = MUL_A_W'(r_p);
                           mul_b = MUL_B_W'($signed({1'b0, K_LOG2_10_Q32})); end
            S_EXP:   begin mul_a = MUL_A_W'($signed({1'b0, r_prod[31:2]}));
                           mul_b = MUL_B_W'($signed({1'b0, K_LN2_Q30})); end
            S_TMUL:  begin mul_a = MUL_A_W'($signed({1'b0, r_term}));
                           mul_b = MUL_B_W'($signed({1'b0, r_x})); end
            S_TDIV:  begin mul_a = MUL_A_W'($signed({1'b0, recip_k(r_k)}));
                           mul_b = MUL_B_W'($signed({1'b0, r_dq})); end
            S_LSQ:   begin mul_a = MUL_A_W'($signed({1'b0, r_lm}));
                           mul_b = MUL_B_W'($signed({1'b0, r_lm})); end
            S_SCALE: begin mul_a = r_total;
                           mul_b = MUL_B_W'($signed({1'b0, K_DB64_Q16})); end
            default: ;
        endcase
    end

    swpp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (r_prod)
    );

    // Result selection at the last bin
    logic  out_free;
    logic  res_now;
    t_pwr  res_pick;
    assign out_free = !o_valid || !i_stall;
    always_comb begin
        res_now  = 1'b0;
        res_pick = PWR_MINUS_300;
        if (r_state == S_BINEND && r_last) begin
            if (r_cfg_mode == MODE_PEAK) begin
                res_now  = 1'b1;
                res_pick = r_max;
            end else if (r_cfg_mode == MODE_POWER) begin
                if (r_cnt == '0) begin
                    res_now  = 1'b1;
                    res_pick = r_first;
                end else if (r_cfg_width == '0) begin
                    res_now  = 1'b1;
                    res_pick = PWR_MAX;
                end
            end else begin
                res_now = 1'b1;
            end
        end else if (r_state == S_ROUND) begin
            res_now  = 1'b1;
            res_pick = rnd_sat;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_WIN;
            S_WIN:    n_state = in_win ? S_EXP : S_BINEND;
            S_EXP:    n_state = S_XLD;
            S_XLD:    n_state = S_TMUL;
            S_TMUL:   n_state = S_TPROD;
            S_TPROD:  n_state = S_TDIV;
            S_TDIV:   n_state = S_TADD;
            S_TADD:   n_state = (r_k == 4'd12) ? S_ACC : S_TMUL;
            S_ACC:    n_state = S_BINEND;
            S_BINEND: begin
                if (!r_last)                     n_state = S_IDLE;
                else if (res_now && out_free)    n_state = S_IDLE;
                else if (!res_now)               n_state = S_LNORM;
            end
            S_LNORM:  if (r_v[WIDTH_W-1]) n_state = S_LSQ;
            S_LSQ:    n_state = S_LSQ2;
            S_LSQ2:   n_state = (r_li == 5'd23) ? S_LDONE : S_LSQ;
            S_LDONE:  n_state = r_lsel ? S_SCALE : S_LNORM;
            S_SCALE:  n_state = S_ROUND;
            S_ROUND:  if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode  <= '0;
            r_cfg_start <= '0;
            r_cfg_step  <= '0;
            r_cfg_lo    <= '0;
            r_cfg_hi    <= '0;
            r_cfg_width <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:  r_cfg_mode  <= i_cfg_data[1:0];
                REG_START: r_cfg_start <= $signed(i_cfg_data);
                REG_STEP:  r_cfg_step  <= i_cfg_data[STEP_W-1:0];
                REG_LOW:   r_cfg_lo    <= $signed(i_cfg_data);
                REG_HIGH:  r_cfg_hi    <= $signed(i_cfg_data);
                REG_WIDTH: r_cfg_width <= i_cfg_data[WIDTH_W-1:0];
                default:   ;
            endcase
        end
    end

    // Trace control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_bin_freq <= '0;
            r_max      <= '0;
            r_first    <= '0;
            r_sum      <= '0;
            r_exp      <= '0;
            r_cnt      <= '0;
            o_valid    <= 1'b0;
        end else begin
            if (res_now && out_free) o_valid <= 1'b1;
            else if (!i_stall)       o_valid <= 1'b0;
            case (r_state)
                S_WIN: begin
                    if (!r_in_frame) begin
                        r_first <= r_p;
                        r_sum   <= '0;
                        r_exp   <= '0;
                    end
                    r_in_frame <= 1'b1;
                    r_max      <= (r_in_frame && !(in_win && r_p > r_max)) ? r_max : r_p;
                    if (in_win) begin
                        if (!r_in_frame)    r_cnt <= CNT_W'(1) <= CAP ? CNT_W'(1) : '0;
                        else if (r_cnt < CAP) r_cnt <= r_cnt + 1'b1;
                    end else if (!r_in_frame) begin
                        r_cnt <= '0;
                    end
                    r_bin_freq <= (f_sum > FREQ_SAT) ? FREQ_SAT[BINF_W-1:0]
                                                      : f_sum[BINF_W-1:0];
                end
                S_ACC: begin
                    r_sum <= acc_sum;
                    r_exp <= acc_exp;
                end
                S_BINEND: begin
                    if (r_last) r_in_frame <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_p    <= i_bin_power_dbm;
                r_last <= i_last_bin;
            end
            S_EXP: r_n <= r_prod[40:32];
            S_XLD: begin
                r_x    <= r_prod[59:30];
                r_term <= ONE_Q30;
                r_m    <= 32'(ONE_Q30);
                r_k    <= 4'd1;
            end
            S_TPROD: begin
                r_dq   <= r_prod[59:30];
            end
            S_TADD: begin
                r_term <= {1'b0, div_q};
                r_m    <= r_m + 32'(div_q);
                r_k    <= r_k + 1'b1;
            end
            S_BINEND: begin
                r_v    <= WIDTH_W'(r_sum);
                r_b    <= 6'(WIDTH_W - 1);
                r_lsel <= 1'b0;
            end
            S_LNORM: begin
                if (r_v[WIDTH_W-1]) begin
                    r_lm   <= r_v[WIDTH_W-1:WIDTH_W-31];
                    r_frac <= '0;
                    r_li   <= '0;
                end else begin
                    r_v <= r_v << 1;
                    r_b <= r_b - 1'b1;
                end
            end
            S_LSQ2: begin
                r_lm   <= sq[31] ? sq[31:1] : sq[30:0];
                r_frac <= {r_frac[22:0], sq[31]};
                r_li   <= r_li + 1'b1;
            end
            S_LDONE: begin
                if (!r_lsel) begin
                    r_total <= ((MUL_A_W'(r_exp) - MUL_A_W'(14)) <<< 24)
                               + MUL_A_W'({r_b, r_frac});
                    r_v     <= r_cfg_width;
                    r_b     <= 6'(WIDTH_W - 1);
                    r_lsel  <= 1'b1;
                end else begin
                    r_total <= r_total - MUL_A_W'({r_b, r_frac});
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_BINEND || r_state == S_ROUND) && res_now && out_free) begin
            o_pick_dbm       <= res_pick;
            o_bins_in_window <= r_cnt;
        end
    end

`ifndef SYNTH
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP)
        else $error("window count above cap");
    a_sum_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BINEND) |-> !r_sum[31])
        else $error("linear sum not normalized");
    a_lm_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LSQ) |-> r_lm[30])
        else $error("log mantissa not normalized");
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && out_free) |=> (o_valid && r_state == S_IDLE))
        else $error("power result not delivered");
`endif

endmodule

// ===== tb/sv/swpp_checker.sv =====
// Checker: watches both channels and the register port, predicts each trace result, compares.
module swpp_checker #(
    parameter int MAX_BINS = swpp_pkg::DEF_MAX_BINS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_stall_in,
    input  logic signed [swpp_pkg::PWR_W-1:0] i_bin_power_dbm,
    input  logic                              i_last_bin,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [swpp_pkg::PWR_W-1:0] i_pick_dbm,
    input  logic [swpp_pkg::CNT_W-1:0]        i_bins_in_window,
    input  logic                              i_cfg_we,
    input  logic [swpp_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [swpp_pkg::CFG_W-1:0]        i_cfg_data,
    output int                                o_pending,
    output int                                o_fail
);
    import swpp_pkg::*;

    localparam int          COUNT_CAP = (MAX_BINS < CNT_LIMIT) ? MAX_BINS : CNT_LIMIT;
    localparam longint      FREQ_SAT  = (64'sd1 <<< 56) - 1;
    localparam longint unsigned TWO_Q30 = 64'd1 << 31;

    typedef struct packed {
        t_pwr pick;
        t_cnt cnt;
    } t_trace_result;

    t_trace_result result_q[$];

    // Shadow registers
    logic [1:0]     mode_r;
    longint         start_f, low_f, high_f;
    longint unsigned step_f, width_f;

    // Trace state
    longint         bin_f;
    longint         peak_pwr, first_pwr;
    longint unsigned lin_mant;
    longint         lin_exp;
    int             win_cnt;
    bit             in_trace;

    // log2 in Q24, zero for zero
    function automatic longint log2_q24(longint unsigned v);
        int              b;
        longint unsigned m;
        longint          frac;
        b    = 0;
        frac = 0;
        if (v == 0) return 0;
        while (b < 63 && (v >> (b + 1)) != 0) b++;
        m = (b >= 30) ? (v >> (b - 30)) : (v << (30 - b));
        for (int i = 0; i < 24; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= TWO_Q30) begin
                m    = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(b) * 16777216 + frac;
    endfunction

    // Accumulate 10^(p/640) into the mantissa/exponent sum
    task automatic accumulate_linear(longint p);
        longint          e, n, d;
        longint unsigned u, r, x, term, m;
        e = p * longint'(K_LOG2_10_Q32);
        u = longint'(e + (64'sd256 <<< 32));
        n = longint'(u >> 32) - 256;
        r = (u & 64'hFFFF_FFFF) >> 2;
        x = (r * longint'(K_LN2_Q30)) >> 30;
        term = longint'(ONE_Q30);
        m    = longint'(ONE_Q30);
        for (int k = 1; k <= 12; k++) begin
            term = ((term * x) >> 30) / k;
            m    = m + term;
        end
        if (m >= TWO_Q30) begin
            m = m >> 1;
            n = n + 1;
        end
        if (lin_mant == 0) begin
            lin_mant = m;
            lin_exp  = n;
        end else if (n > lin_exp) begin
            d        = n - lin_exp;
            lin_mant = (d >= 64) ? 0 : (lin_mant >> d);
            lin_mant = lin_mant + m;
            lin_exp  = n;
        end else begin
            d        = lin_exp - n;
            lin_mant = lin_mant + ((d >= 64) ? 0 : (m >> d));
        end
        if (lin_mant >= TWO_Q30) begin
            lin_mant = lin_mant >> 1;
            lin_exp  = lin_exp + 1;
        end
    endtask

    function automatic longint channel_power();
        longint total, y, q;
        if (win_cnt == 0) return first_pwr;
        if (width_f == 0) return 32767;
        total = (lin_exp - 14) * 16777216 + log2_q24(lin_mant) - log2_q24(width_f);
        y = total * longint'(K_DB64_Q16);
        q = longint'(longint'(unsigned'(y + (64'sd1 <<< 60) + (64'sd1 <<< 39))) >> 40)
            - (64'sd1 <<< 20);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    // One accepted bin
    task automatic take_bin(longint p, bit last);
        longint        f, pick;
        t_trace_result res;
        if (!in_trace) begin
            bin_f     = start_f;
            peak_pwr  = p;
            first_pwr = p;
            lin_mant  = 0;
            lin_exp   = 0;
            win_cnt   = 0;
            in_trace  = 1;
        end
        f = bin_f;
        if (f >= low_f && f <= high_f) begin
            if (p > peak_pwr) peak_pwr = p;
            if (win_cnt < COUNT_CAP) win_cnt++;
            accumulate_linear(p);
        end
        if (longint'(step_f) > FREQ_SAT - f) bin_f = FREQ_SAT;
        else bin_f = f + longint'(step_f);
        if (last) begin
            if (mode_r == MODE_PEAK) pick = peak_pwr;
            else if (mode_r == MODE_POWER) pick = channel_power();
            else pick = PWR_MINUS_300;
            res.pick = t_pwr'(pick);
            res.cnt  = t_cnt'(win_cnt);
            result_q.push_back(res);
            in_trace = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_trace_result want;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            mode_r   <= MODE_PEAK;
            start_f  = 0; low_f = 0; high_f = 0; step_f = 0; width_f = 0;
            bin_f    = 0; peak_pwr = 0; first_pwr = 0;
            lin_mant = 0; lin_exp = 0; win_cnt = 0; in_trace = 0;
            o_fail   <= 0;
            result_q.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE:  mode_r  <= i_cfg_data[1:0];
                    REG_START: start_f = longint'(signed'(i_cfg_data[FREQ_W-1:0]));
                    REG_STEP:  step_f  = longint'(i_cfg_data[STEP_W-1:0]);
                    REG_LOW:   low_f   = longint'(signed'(i_cfg_data[FREQ_W-1:0]));
                    REG_HIGH:  high_f  = longint'(signed'(i_cfg_data[FREQ_W-1:0]));
                    REG_WIDTH: width_f = longint'(i_cfg_data[WIDTH_W-1:0]);
                    default: ;
                endcase
            end
            // input item
            if (i_valid && !i_stall_in)
                take_bin(longint'(i_bin_power_dbm), i_last_bin);
            // result item
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result pick=%0d count=%0d",
                             $time, i_pick_dbm, i_bins_in_window);
                    errs++;
                end else begin
                    want = result_q.pop_front();
                    if (want.pick !== i_pick_dbm) begin
                        $display("%0t: pick_dbm expected %0d actual %0d",
                                 $time, want.pick, i_pick_dbm);
                        errs++;
                    end
                    if (want.cnt !== i_bins_in_window) begin
                        $display("%0t: bins_in_window expected %0d actual %0d",
                                 $time, want.cnt, i_bins_in_window);
                        errs++;
                    end
                end
            end
            o_fail <= o_fail + errs;
        end
        o_pending <= result_q.size();
    end

endmodule

// ===== tb/sv/spectrum_window_peak_power_top_test.sv =====
// Testbench top: drives traces and register settings, gives the verdict.
module spectrum_window_peak_power_top_test;
    import swpp_pkg::*;

    localparam logic [1:0] MODE_OFF     = 2'd2;
    localparam logic [1:0] MODE_OFF_ALT = 2'd3;
    localparam int         ITEM_TARGET  = 1900;
    localparam int         QUIET_AT     = 1750;
    localparam int         SETTLE       = 800;
    localparam int         WDOG_LIMIT   = 20000;
    localparam longint     U16          = 64'sd65536;

    logic                    i_clk, i_rst_n;
    logic                    i_valid, o_stall, i_last_bin;
    logic signed [PWR_W-1:0] i_bin_power_dbm;
    logic                    o_valid, i_stall;
    logic signed [PWR_W-1:0] o_pick_dbm;
    logic [CNT_W-1:0]        o_bins_in_window;
    logic                    i_cfg_we;
    logic [IDX_W-1:0]        i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;

    int pending, fail_cnt, bins_sent, idle_cycles;
    bit quiet;

    spectrum_window_peak_power_top dut (.*);

    swpp_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_bin_power_dbm, .i_last_bin,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_pick_dbm(o_pick_dbm),
        .i_bins_in_window(o_bins_in_window), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_pending(pending), .o_fail(fail_cnt)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver stall in bursts
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            stall_left <= 0;
            i_stall    <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= (stall_left > 1);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 8);
            i_stall    <= 1;
        end else begin
            i_stall <= 0;
        end
    end

    // Watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_bin(logic signed [PWR_W-1:0] p, bit last);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid         <= 1;
        i_bin_power_dbm <= p;
        i_last_bin      <= last;
        forever begin
            @(negedge i_clk);
            if (!o_stall) break;
        end
        @(posedge i_clk);
        bins_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [1:0] mode, longint start, longint step,
                            longint lo, longint hi, longint width);
        logic [CFG_W-1:0] vals[6];
        wait_idle();
        vals[REG_MODE]  = CFG_W'(mode);
        vals[REG_START] = CFG_W'(start);
        vals[REG_STEP]  = CFG_W'(step) & ((56'd1 << STEP_W) - 1);
        vals[REG_LOW]   = CFG_W'(lo);
        vals[REG_HIGH]  = CFG_W'(hi);
        vals[REG_WIDTH] = CFG_W'(width) & ((56'd1 << WIDTH_W) - 1);
        for (int i = 0; i < 6; i++) begin
            i_cfg_we   <= 1;
            i_cfg_idx  <= IDX_W'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 0;
    endtask

    function automatic longint rand56();
        return longint'(signed'(56'({$urandom, $urandom})));
    endfunction

    function automatic logic signed [PWR_W-1:0] rand_pwr();
        if ($urandom_range(0, 9) < 4) return PWR_W'($urandom);
        return PWR_W'($urandom_range(0, 12800)) - 16'sd9600;
    endfunction

    initial begin
        longint start, step, lo, hi, width;
        int     len;
        logic [1:0] mode;
        i_rst_n = 0; i_valid = 0; i_stall = 0; i_last_bin = 0; i_bin_power_dbm = 0;
        i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        quiet = 0; bins_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Peak: first bin outside the window still seeds the maximum
        set_regs(MODE_PEAK, -2 * U16, U16, 0, 3 * U16, 4 * U16);
        send_bin(16'sh7FFF, 0);
        send_bin(-16'sd5, 0);
        send_bin(16'sd100, 0);
        send_bin(-16'sh8000, 0);
        send_bin(16'sd200, 1);
        // Power mode over extremes
        set_regs(MODE_POWER, 0, U16, 0, 3 * U16, 4 * U16);
        send_bin(16'sh7FFF, 0);
        send_bin(-16'sh8000, 0);
        send_bin(16'sd0, 0);
        send_bin(16'sd640, 1);
        // Power mode, empty window returns first bin
        set_regs(MODE_POWER, 0, U16, 10 * U16, 5 * U16, 4 * U16);
        send_bin(-16'sd1234, 0);
        send_bin(16'sd77, 1);
        // Power mode, zero width saturates
        set_regs(MODE_POWER, 0, U16, 0, 3 * U16, 0);
        send_bin(-16'sd640, 0);
        send_bin(16'sd0, 1);
        // Modes with no search
        set_regs(MODE_OFF, 0, U16, 0, 3 * U16, 4 * U16);
        send_bin(16'sd10, 0);
        send_bin(16'sd20, 1);
        set_regs(MODE_OFF_ALT, 0, U16, 0, 3 * U16, 4 * U16);
        send_bin(16'sd30, 1);
        // Start near the top of the frequency range: later bins step above every window
        set_regs(MODE_PEAK, (64'sd1 <<< 55) - 3, (64'sd1 <<< 48) - 1,
                 (64'sd1 <<< 55) - 3, (64'sd1 <<< 55) - 1, (64'sd1 <<< 55) - 1);
        send_bin(-16'sd1, 0);
        send_bin(16'sd500, 0);
        send_bin(16'sd900, 0);
        send_bin(16'sd1000, 1);
        // Long trace, window never reached
        set_regs(MODE_PEAK, 0, U16, -100 * U16, -U16, U16);
        for (int i = 0; i < 300; i++) send_bin(rand_pwr(), i == 299);

        // Random phases
        while (bins_sent < ITEM_TARGET) begin
            mode  = 2'($urandom_range(0, 9) < 8 ? $urandom_range(0, 1) : $urandom_range(2, 3));
            start = ($urandom_range(0, 4) == 0) ? rand56()
                    : longint'(signed'(40'({$urandom, $urandom})));
            step  = ($urandom_range(0, 4) == 0) ? longint'({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF)
                    : longint'($urandom_range(1, 1 << 24));
            lo    = start + step * $urandom_range(0, 4) - longint'($urandom_range(0, 3));
            hi    = lo + step * $urandom_range(0, 6);
            if ($urandom_range(0, 7) == 0) begin
                lo = rand56();
                hi = rand56();
            end
            case ($urandom_range(0, 3))
                0: width = 0;
                1: width = (64'sd1 <<< 55) - 1;
                2: width = longint'({$urandom, $urandom} & 55'h7F_FFFF_FFFF_FFFF);
                default: width = step * $urandom_range(1, 8);
            endcase
            set_regs(mode, start, step, lo, hi, width);
            repeat ($urandom_range(4, 12)) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    if (bins_sent >= QUIET_AT) quiet = 1;
                    send_bin(rand_pwr(), i == len - 1);
                end
            end
        end

        // Drain
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
